[sv/nsbc_pkg.sv]
// Shared types, cipher tables and GF(16) helper for the nibble SPN encryptor.
`default_nettype none

package nsbc_pkg;

  typedef logic [3:0]  nib_t;
  typedef logic [63:0] block_t;

  typedef enum logic [1:0] {
    CFG_KEY_SIZE   = 2'd0,
    CFG_KEY_FIRST  = 2'd1,
    CFG_KEY_SECOND = 2'd2
  } cfg_idx_t;

  localparam int NUM_RND         = 48;
  localparam int NUM_RND_SHORT   = 32;
  localparam int RND_PER_STEP    = 4;
  localparam int NUM_STEP        = NUM_RND / RND_PER_STEP;
  localparam int MAX_KEY_NIBBLES = 32;
  localparam int KS_MIN          = 64;
  localparam int KS_MAX          = 4 * MAX_KEY_NIBBLES;
  localparam int MIN_NIB         = KS_MIN / 4;
  localparam int NUM_CNT         = MAX_KEY_NIBBLES - MIN_NIB + 1;

  localparam nib_t SBOX [16] = '{
    4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
    4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
  };

  localparam nib_t MDS [4][4] = '{
    '{4'd4,  4'd1,  4'd2,  4'd2},
    '{4'd8,  4'd6,  4'd5,  4'd6},
    '{4'd11, 4'd14, 4'd10, 4'd9},
    '{4'd2,  4'd2,  4'd15, 4'd11}
  };

  localparam logic [5:0] RCON [NUM_RND] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  typedef struct packed {
    nib_t ks_hi;
    nib_t ks_lo;
    logic long_key;
  } rnd_cfg_t;

  // GF(16) multiply, x^4+x+1
  function automatic nib_t gf_mul(input nib_t a, input nib_t b);
    nib_t x;
    nib_t acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[sv/nsbc_key_sched.sv]
// Per-step round key vectors, rotated through the key nibbles modulo the nibble count.
`default_nettype none

module nsbc_key_sched import nsbc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   [7:0] ks_sat,
  input  wire block_t key_first,
  input  wire block_t key_second,
  output block_t      key_step_r [NUM_STEP]
);

  logic [5:0] count;
  logic [4:0] cnt_idx;
  logic [4:0] off_tab [NUM_STEP][NUM_CNT];
  nib_t       kn [MAX_KEY_NIBBLES];
  block_t     key_step_nxt [NUM_STEP];

  assign count   = ks_sat[7:2];
  assign cnt_idx = 5'(count - 6'(MIN_NIB));

  for (genvar s = 0; s < NUM_STEP; s++) begin : g_step
    for (genvar c = 0; c < NUM_CNT; c++) begin : g_cnt
      localparam logic [4:0] OFF = 5'((16 * (s + 1)) % (c + MIN_NIB));
      assign off_tab[s][c] = OFF;
    end
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      kn[j]      = key_first[63 - 4*j -: 4];
      kn[j + 16] = key_second[63 - 4*j -: 4];
    end
  end

  always_comb begin
    logic [5:0] idx;
    for (int s = 0; s < NUM_STEP; s++) begin
      for (int i = 0; i < 16; i++) begin
        idx = {1'b0, off_tab[s][cnt_idx]} + 6'(i);
        if (idx >= count) idx = idx - count;
        key_step_nxt[s][63 - 4*i -: 4] = kn[idx[4:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    key_step_r <= key_step_nxt;
  end

endmodule

`default_nettype wire

[sv/nsbc_round_stage.sv]
// One registered cipher round with optional trailing key add; long-only rounds pass data through for short keys.
`default_nettype none

module nsbc_round_stage import nsbc_pkg::*; #(
  parameter int RND = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_vld,
  input  wire block_t   in_dat,
  input  wire rnd_cfg_t rcfg,
  input  wire block_t   key,
  output logic          vld_r,
  output block_t        dat_r
);

  localparam logic [5:0] RC        = RCON[RND];
  localparam bit         ADD_KEY   = (RND % RND_PER_STEP) == (RND_PER_STEP - 1);
  localparam bit         LONG_ONLY = RND >= NUM_RND_SHORT;

  block_t dat_nxt;

  always_comb begin
    nib_t   c [16];
    nib_t   s [16];
    nib_t   t [16];
    nib_t   acc;
    block_t r_out;
    for (int k = 0; k < 16; k++) c[k] = in_dat[63 - 4*k -: 4];
    c[0]  = c[0]  ^ rcfg.ks_hi;
    c[4]  = c[4]  ^ (4'h1 ^ rcfg.ks_hi);
    c[8]  = c[8]  ^ (4'h2 ^ rcfg.ks_lo);
    c[12] = c[12] ^ (4'h3 ^ rcfg.ks_lo);
    c[1]  = c[1]  ^ {1'b0, RC[5:3]};
    c[9]  = c[9]  ^ {1'b0, RC[5:3]};
    c[5]  = c[5]  ^ {1'b0, RC[2:0]};
    c[13] = c[13] ^ {1'b0, RC[2:0]};
    for (int k = 0; k < 16; k++) s[k] = SBOX[c[k]];
    for (int row = 0; row < 4; row++)
      for (int col = 0; col < 4; col++)
        t[row*4 + col] = s[row*4 + ((col + row) & 3)];
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc = acc ^ gf_mul(MDS[row][k], t[k*4 + col]);
        r_out[63 - 4*(row*4 + col) -: 4] = acc;
      end
    r_out = r_out ^ (ADD_KEY ? key : '0);
    if (LONG_ONLY && !rcfg.long_key) begin
      dat_nxt = in_dat;
    end else begin
      dat_nxt = r_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/nibble_spn_block_cipher_encrypt_unit.sv]
// Top level of the pipelined nibble SPN block cipher encryptor.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   in       | in_valid/in_stall  | in_plaintext   [63:0]
//   out      | out_valid/out_stall| out_ciphertext [63:0]
//   cfg      | cfg_valid/cfg_ready| cfg_index [1:0], cfg_data [63:0]
//
// One block per cycle unless out_stall holds a valid result; key-add input stage plus 48 round stages.
// Short keys pass the last 16 round stages unchanged, so latency is fixed.
// Reset is synchronous: valid bits clear, key_size returns to 64, keys to zero.
// out_stall with out_valid freezes the whole round pipeline; the input stage still fills if empty.
`default_nettype none

module nibble_spn_block_cipher_encrypt_unit import nsbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire block_t      in_plaintext,
  output logic             out_valid,
  input  wire logic        out_stall,
  output block_t           out_ciphertext,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [7:0] key_size_r;
  block_t     key_first_r;
  block_t     key_second_r;
  logic [7:0] ks_sat;
  rnd_cfg_t   rcfg;
  block_t     key_step [NUM_STEP];
  logic       en;
  logic       ld0;
  logic       vld0_r;
  block_t     dat0_r;
  logic       vld [NUM_RND + 1];
  block_t     dat [NUM_RND + 1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r   <= 8'(KS_MIN);
      key_first_r  <= '0;
      key_second_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_SIZE:   key_size_r   <= cfg_data[7:0];
        CFG_KEY_FIRST:  key_first_r  <= cfg_data;
        CFG_KEY_SECOND: key_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_size_r < 8'(KS_MIN)) begin
      ks_sat = 8'(KS_MIN);
    end else if (key_size_r > 8'(KS_MAX)) begin
      ks_sat = 8'(KS_MAX);
    end else begin
      ks_sat = key_size_r;
    end
  end

  assign rcfg.ks_hi    = ks_sat[7:4];
  assign rcfg.ks_lo    = ks_sat[3:0];
  assign rcfg.long_key = ks_sat > 8'(KS_MIN);

  nsbc_key_sched u_key_sched (
    .clk        (clk),
    .ks_sat     (ks_sat),
    .key_first  (key_first_r),
    .key_second (key_second_r),
    .key_step_r (key_step)
  );

  assign en       = !(out_valid && out_stall);
  assign ld0      = !vld0_r || en;
  assign in_stall = !ld0;

  // input stage: initial key add uses key nibbles 0..15
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (ld0) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0 && in_valid) begin
      dat0_r <= in_plaintext ^ key_first_r;
    end
  end

  assign vld[0] = vld0_r;
  assign dat[0] = dat0_r;

  for (genvar r = 0; r < NUM_RND; r++) begin : g_rnd
    nsbc_round_stage #(.RND(r)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (vld[r]),
      .in_dat (dat[r]),
      .rcfg   (rcfg),
      .key    (key_step[r / RND_PER_STEP]),
      .vld_r  (vld[r + 1]),
      .dat_r  (dat[r + 1])
    );
  end

  assign out_valid      = vld[NUM_RND];
  assign out_ciphertext = dat[NUM_RND];

endmodule

`default_nettype wire

[sv/nsbc_checker.sv]
// Port-level checker for the nibble SPN encryptor and its bind.
`default_nettype none

module nsbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_ciphertext,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ciphertext))
    else $error("stalled result changed or dropped");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config transaction refused");

endmodule

bind nibble_spn_block_cipher_encrypt_unit nsbc_checker u_nsbc_checker (.*);

`default_nettype wire
